// ----- sv/mlfc_pkg.sv -----
// ============================================================================
// mlfc_pkg: shared definitions for the motion light fade controller
// Holds field widths, reset values, register indexes and the sequencer states.
// ============================================================================
`default_nettype none

package mlfc_pkg;

    // Field widths
    localparam int DUTY_W      = 8;
    localparam int TIME_W      = 32;
    localparam int HOLD_W      = 16;
    localparam int FADE_W      = 16;
    localparam int FRAME_CNT_W = 4;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    // Derived arithmetic widths
    localparam int MS_PER_S_W  = 10;
    localparam int HOLD_LIM_W  = HOLD_W + MS_PER_S_W;
    localparam int PROD_W      = DUTY_W + FADE_W;
    localparam int DIV_STEPS   = PROD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [MS_PER_S_W-1:0] MS_PER_S = MS_PER_S_W'(1000);

    // Parameter defaults
    localparam int FRAME_PERIOD_MS_DEF     = 20;
    localparam int NOTIFY_EVERY_FRAMES_DEF = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_LEVEL   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_HOLD    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FADE_DUR     = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [DUTY_W-1:0] AUTO_LEVEL_RST = DUTY_W'(255);
    localparam logic [HOLD_W-1:0] AUTO_HOLD_RST  = HOLD_W'(60);
    localparam logic [FADE_W-1:0] FADE_DUR_RST   = FADE_W'(500);

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HOLD,
        ST_AUTO,
        ST_FRAME,
        ST_ELAPSED,
        ST_END,
        ST_DIV,
        ST_APPLY,
        ST_DONE
    } mlfc_state_t;

endpackage

`default_nettype wire

// ----- sv/mlfc_if.sv -----
// ============================================================================
// mlfc_if: channel interfaces of the motion light fade controller
// Input request, result request and configuration write channels.
// ============================================================================
`default_nettype none

// Input request channel: tick or manual command.
interface mlfc_item_if;
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [mlfc_pkg::TIME_W-1:0]     now_ms;
    logic                            motion;
    logic [mlfc_pkg::DUTY_W-1:0]     level;

    modport source (output valid, cmd, now_ms, motion, level, input ready);
    modport sink   (input valid, cmd, now_ms, motion, level, output ready);
endinterface

// Result request channel.
interface mlfc_result_if;
    logic                            valid;
    logic                            ready;
    logic [mlfc_pkg::DUTY_W-1:0]     duty;
    logic                            light_on;
    logic                            auto_on;
    logic                            fading;
    logic                            changed;

    modport source (output valid, duty, light_on, auto_on, fading, changed, input ready);
    modport sink   (input valid, duty, light_on, auto_on, fading, changed, output ready);
endinterface

// Configuration write channel.
interface mlfc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mlfc_pkg::CFG_IDX_W-1:0]    index;
    logic [mlfc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/motion_light_fade_controller.sv -----
// ============================================================================
// motion_light_fade_controller: PWM light with motion timeout and linear fade
// Sequencer that applies manual and motion requests, then advances a fade
// frame through one multiplier step and a restoring divider.
// ============================================================================
//
//  Channel | Modport | Request carries                       | Accepted when
//  --------+---------+--------------------------------------+-------------------
//  item    | sink    | cmd, now_ms, motion, level           | valid && ready
//  result  | source  | duty, light_on, auto_on, fading, ... | valid && ready
//  cfg     | sink    | index, data                          | valid (ready = 1)
//
//  A manual command passes the hold, auto and done steps; a tick adds the frame
//  step, a frame that ends the fade the elapsed and end steps, and an intermediate
//  frame the bit-serial divider (one quotient bit per cycle) and the apply step.
//  The item channel is ready only while the sequencer is idle.
//  A finished result waits in the output register; the sequencer stalls in its
//  last step only if the previous result has not been taken yet.
//  Reset is asynchronous, active low; the request latch, working and payload registers are not reset.
//
`default_nettype none

module motion_light_fade_controller #(
    parameter int FRAME_PERIOD_MS     = mlfc_pkg::FRAME_PERIOD_MS_DEF,
    parameter int NOTIFY_EVERY_FRAMES = mlfc_pkg::NOTIFY_EVERY_FRAMES_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    mlfc_item_if.sink     item,
    mlfc_result_if.source result,
    mlfc_cfg_if.sink      cfg
);
    import mlfc_pkg::*;

    localparam logic [TIME_W-1:0]      FRAME_PERIOD = TIME_W'(FRAME_PERIOD_MS);
    localparam logic [FRAME_CNT_W-1:0] NOTIFY_CNT   = FRAME_CNT_W'(NOTIFY_EVERY_FRAMES);
    localparam logic [DIV_CNT_W-1:0]   DIV_LAST     = DIV_CNT_W'(DIV_STEPS - 1);

    // Sequencer
    mlfc_state_t state_reg, state_next;

    // Configuration registers
    logic              auto_enabled_reg;
    logic [DUTY_W-1:0] auto_level_reg;
    logic [HOLD_W-1:0] auto_hold_reg;
    logic [FADE_W-1:0] fade_dur_reg;

    // Controller state
    logic [DUTY_W-1:0]      brightness_reg, brightness_next;
    logic [DUTY_W-1:0]      start_level_reg, start_level_next;
    logic [DUTY_W-1:0]      target_level_reg, target_level_next;
    logic [TIME_W-1:0]      start_time_reg, start_time_next;
    logic [FADE_W-1:0]      fade_length_reg, fade_length_next;
    logic [TIME_W-1:0]      last_frame_reg, last_frame_next;
    logic [FRAME_CNT_W-1:0] frame_count_reg, frame_count_next;
    logic                   fade_active_reg, fade_active_next;
    logic                   auto_active_reg, auto_active_next;
    logic [TIME_W-1:0]      motion_time_reg, motion_time_next;
    logic                   changed_reg, changed_next;

    // Latched request and working registers
    logic                   cmd_reg;
    logic [TIME_W-1:0]      now_reg;
    logic                   motion_reg;
    logic [DUTY_W-1:0]      level_reg;
    logic [HOLD_LIM_W-1:0]  hold_limit_reg, hold_limit_next;
    logic [TIME_W-1:0]      elapsed_reg, elapsed_next;
    logic [FADE_W:0]        rem_reg, rem_next;
    logic [PROD_W-1:0]      quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0] out_duty_reg;
    logic              out_auto_reg;
    logic              out_fading_reg;
    logic              out_changed_reg;

    // Shared handshake and condition signals
    logic              item_take;
    logic              out_load;
    logic [TIME_W-1:0] hold_diff;
    logic              hold_expired;
    logic [TIME_W-1:0] frame_diff;
    logic              frame_due;
    logic              fade_ends;
    logic [FADE_W:0]   div_trial;
    logic              div_ge;
    logic              fade_down;
    logic [DUTY_W-1:0] span_mag;
    logic              req_valid;
    logic [DUTY_W-1:0] req_level;

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign item_take  = item.valid && item.ready;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    // Hold timeout and frame throttle compares
    assign hold_diff    = now_reg - motion_time_reg;
    assign hold_expired = hold_diff >= TIME_W'(hold_limit_reg);
    assign frame_diff   = now_reg - last_frame_reg;
    assign frame_due    = fade_active_reg && (frame_diff >= FRAME_PERIOD);
    assign fade_ends    = (fade_length_reg == '0)
                          || (elapsed_reg >= TIME_W'(fade_length_reg));

    // Restoring divider step: one quotient bit per cycle
    assign div_trial = {rem_reg[FADE_W-1:0], quo_reg[PROD_W-1]};
    assign div_ge    = div_trial >= {1'b0, fade_length_reg};

    // Fade direction and span magnitude
    assign fade_down = target_level_reg < start_level_reg;
    assign span_mag  = fade_down ? (start_level_reg - target_level_reg)
                                 : (target_level_reg - start_level_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_enabled_reg <= 1'b0;
            auto_level_reg   <= AUTO_LEVEL_RST;
            auto_hold_reg    <= AUTO_HOLD_RST;
            fade_dur_reg     <= FADE_DUR_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_AUTO_ENABLED: auto_enabled_reg <= cfg.data[0];
                REG_AUTO_LEVEL:   auto_level_reg   <= cfg.data[DUTY_W-1:0];
                REG_AUTO_HOLD:    auto_hold_reg    <= cfg.data[HOLD_W-1:0];
                REG_FADE_DUR:     fade_dur_reg     <= cfg.data[FADE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (item_take) state_next = ST_HOLD;
            ST_HOLD:    state_next = ST_AUTO;
            ST_AUTO:    state_next = cmd_reg ? ST_DONE : ST_FRAME;
            ST_FRAME:   state_next = frame_due ? ST_ELAPSED : ST_DONE;
            ST_ELAPSED: state_next = ST_END;
            ST_END:     state_next = fade_ends ? ST_DONE : ST_DIV;
            ST_DIV:     if (div_cnt_reg == DIV_LAST) state_next = ST_APPLY;
            ST_APPLY:   state_next = ST_DONE;
            ST_DONE:    if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Duty request raised in the auto step, and the changed flag
    always_comb
    begin
        req_valid        = 1'b0;
        req_level        = '0;
        auto_active_next = auto_active_reg;
        motion_time_next = motion_time_reg;
        changed_next     = changed_reg;
        if (state_reg == ST_IDLE)
        begin
            changed_next = 1'b0;
        end
        else if (state_reg == ST_AUTO)
        begin
            if (cmd_reg)
            begin
                auto_active_next = 1'b0;
                req_valid        = 1'b1;
                req_level        = level_reg;
                changed_next     = (level_reg != brightness_reg);
            end
            else if (auto_enabled_reg)
            begin
                if (motion_reg)
                begin
                    if (!auto_active_reg)
                    begin
                        if (brightness_reg == '0)
                        begin
                            req_valid        = 1'b1;
                            req_level        = auto_level_reg;
                            auto_active_next = 1'b1;
                            motion_time_next = now_reg;
                            changed_next     = 1'b1;
                        end
                    end
                    else
                    begin
                        motion_time_next = now_reg;
                    end
                end
                else if (auto_active_reg && hold_expired)
                begin
                    req_valid        = 1'b1;
                    req_level        = '0;
                    auto_active_next = 1'b0;
                    changed_next     = 1'b1;
                end
            end
        end
        else if (state_reg == ST_END)
        begin
            if (fade_ends)
                changed_next = 1'b1;
        end
        else if (state_reg == ST_APPLY)
        begin
            if (frame_count_reg + 1'b1 >= NOTIFY_CNT)
                changed_next = 1'b1;
        end
    end

    // Fade datapath: hold limit, request apply, frame throttle, multiply, divide, apply
    always_comb
    begin
        brightness_next   = brightness_reg;
        start_level_next  = start_level_reg;
        target_level_next = target_level_reg;
        start_time_next   = start_time_reg;
        fade_length_next  = fade_length_reg;
        last_frame_next   = last_frame_reg;
        frame_count_next  = frame_count_reg;
        fade_active_next  = fade_active_reg;
        hold_limit_next   = hold_limit_reg;
        elapsed_next      = elapsed_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        div_cnt_next      = div_cnt_reg;
        unique case (state_reg)
            ST_HOLD:
            begin
                hold_limit_next = HOLD_LIM_W'(auto_hold_reg) * HOLD_LIM_W'(MS_PER_S);
            end
            ST_AUTO:
            begin
                if (req_valid && (req_level != brightness_reg))
                begin
                    if (fade_dur_reg == '0)
                    begin
                        brightness_next  = req_level;
                        fade_active_next = 1'b0;
                    end
                    else
                    begin
                        fade_length_next  = fade_dur_reg;
                        start_level_next  = brightness_reg;
                        target_level_next = req_level;
                        frame_count_next  = '0;
                        start_time_next   = now_reg;
                        fade_active_next  = 1'b1;
                    end
                end
            end
            ST_FRAME:
            begin
                if (frame_due)
                    last_frame_next = now_reg;
            end
            ST_ELAPSED:
            begin
                elapsed_next = (now_reg >= start_time_reg) ? (now_reg - start_time_reg) : '0;
            end
            ST_END:
            begin
                if (fade_ends)
                begin
                    brightness_next  = target_level_reg;
                    fade_active_next = 1'b0;
                end
                else
                begin
                    quo_next     = PROD_W'(span_mag) * PROD_W'(elapsed_reg[FADE_W-1:0]);
                    rem_next     = '0;
                    div_cnt_next = '0;
                end
            end
            ST_DIV:
            begin
                rem_next     = div_ge ? (div_trial - {1'b0, fade_length_reg}) : div_trial;
                quo_next     = {quo_reg[PROD_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            ST_APPLY:
            begin
                brightness_next = fade_down ? (start_level_reg - quo_reg[DUTY_W-1:0])
                                            : (start_level_reg + quo_reg[DUTY_W-1:0]);
                frame_count_next = frame_count_reg + 1'b1;
                if (frame_count_reg + 1'b1 >= NOTIFY_CNT)
                    frame_count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    // Control and controller state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            brightness_reg   <= '0;
            start_level_reg  <= '0;
            target_level_reg <= '0;
            start_time_reg   <= '0;
            fade_length_reg  <= '0;
            last_frame_reg   <= '0;
            frame_count_reg  <= '0;
            fade_active_reg  <= 1'b0;
            auto_active_reg  <= 1'b0;
            motion_time_reg  <= '0;
            changed_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            brightness_reg   <= brightness_next;
            start_level_reg  <= start_level_next;
            target_level_reg <= target_level_next;
            start_time_reg   <= start_time_next;
            fade_length_reg  <= fade_length_next;
            last_frame_reg   <= last_frame_next;
            frame_count_reg  <= frame_count_next;
            fade_active_reg  <= fade_active_next;
            auto_active_reg  <= auto_active_next;
            motion_time_reg  <= motion_time_next;
            changed_reg      <= changed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Request latch, working registers and result payload
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            cmd_reg    <= item.cmd;
            now_reg    <= item.now_ms;
            motion_reg <= item.motion;
            level_reg  <= item.level;
        end
        hold_limit_reg <= hold_limit_next;
        elapsed_reg    <= elapsed_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        div_cnt_reg    <= div_cnt_next;
        if (out_load)
        begin
            out_duty_reg    <= brightness_reg;
            out_auto_reg    <= auto_active_reg;
            out_fading_reg  <= fade_active_reg;
            out_changed_reg <= changed_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.duty     = out_duty_reg;
    assign result.light_on = (out_duty_reg != '0);
    assign result.auto_on  = out_auto_reg;
    assign result.fading   = out_fading_reg;
    assign result.changed  = out_changed_reg;

    // A running fade always has a nonzero length.
    a_fade_len: assert property (@(posedge clk) disable iff (!rst_n)
        fade_active_reg |-> (fade_length_reg != '0))
        else $error("fade active with zero length");

    // The divided step never exceeds the span of the fade.
    a_quot_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) |->
            ((quo_reg[PROD_W-1:DUTY_W] == '0) && (quo_reg[DUTY_W-1:0] <= span_mag)))
        else $error("fade quotient beyond span");

    // An accepted request starts the sequence and closes the input.
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |=> ((state_reg == ST_HOLD) && !item.ready))
        else $error("sequencer did not start on accepted request");

endmodule

`default_nettype wire

// ----- tb/motion_light_fade_controller_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// motion_light_fade_controller_test: self-checking bench for the light block
// A driver feeds tick and manual requests from a queue, a behavioral copy of
// the controller predicts duty, flags and notifications for every accepted
// request, and a monitor compares each returned request field by field while
// both sides of the handshake idle and stall at random.
// ============================================================================

module motion_light_fade_controller_test;

    import mlfc_pkg::*;

    // Request kinds carried on the cmd bit.
    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_MANUAL = 1'b1
    } lamp_op_t;

    typedef struct packed {
        lamp_op_t          op;
        logic [TIME_W-1:0] now_ms;
        logic              motion;
        logic [DUTY_W-1:0] level;
    } lamp_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              light_on;
        logic              auto_on;
        logic              fading;
        logic              changed;
    } lamp_result_t;

    // An index past the register map; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(255);

    localparam logic [TIME_W-1:0]      FRAME_MS = TIME_W'(FRAME_PERIOD_MS_DEF);
    localparam logic [FRAME_CNT_W-1:0] NOTIFY_N = FRAME_CNT_W'(NOTIFY_EVERY_FRAMES_DEF);

    localparam int LONG_HOLD_AFTER  = 150;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int RUN_LIMIT_NS     = 3_000_000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mlfc_item_if   item_bus ();
    mlfc_result_if res_bus ();
    mlfc_cfg_if    cfg_bus ();

    motion_light_fade_controller u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    always #5 clk = ~clk;

    // Requests waiting to be sent and outputs the controller copy predicts.
    lamp_item_t   lamp_requests[$];
    lamp_result_t predicted_outputs[$];
    lamp_item_t   offered_item;

    int   mismatches   = 0;
    int   results_seen;
    logic quiet_run    = 1'b0;
    logic [TIME_W-1:0] wall_ms;

    // Behavioral copy of the registers.
    logic              cfg_auto_en;
    logic [DUTY_W-1:0] cfg_auto_lvl;
    logic [HOLD_W-1:0] cfg_hold;
    logic [FADE_W-1:0] cfg_fade;

    // Behavioral copy of the lamp state.
    logic [DUTY_W-1:0]      lamp_duty;
    logic [DUTY_W-1:0]      fade_from;
    logic [DUTY_W-1:0]      fade_to;
    logic [TIME_W-1:0]      fade_t0;
    logic [FADE_W-1:0]      fade_len;
    logic [TIME_W-1:0]      frame_t;
    logic [FRAME_CNT_W-1:0] frames;
    logic                   fade_run;
    logic                   auto_run;
    logic [TIME_W-1:0]      motion_t;

    function automatic void lamp_reset();
        cfg_auto_en  = 1'b0;
        cfg_auto_lvl = AUTO_LEVEL_RST;
        cfg_hold     = AUTO_HOLD_RST;
        cfg_fade     = FADE_DUR_RST;
        lamp_duty    = '0;
        fade_from    = '0;
        fade_to      = '0;
        fade_t0      = '0;
        fade_len     = '0;
        frame_t      = '0;
        frames       = '0;
        fade_run     = 1'b0;
        auto_run     = 1'b0;
        motion_t     = '0;
    endfunction

    // A new duty either lands at once or starts a fade; equal duty is a no-op.
    function automatic bit duty_request(input logic [DUTY_W-1:0] lvl,
                                        input logic [TIME_W-1:0] now);
        if (lvl == lamp_duty)
            return 1'b0;
        if (cfg_fade == '0)
        begin
            lamp_duty = lvl;
            fade_run  = 1'b0;
        end
        else
        begin
            fade_len  = cfg_fade;
            fade_from = lamp_duty;
            fade_to   = lvl;
            frames    = '0;
            fade_t0   = now;
            fade_run  = 1'b1;
        end
        return 1'b1;
    endfunction

    // One throttled fade frame; returns 1 when listeners are to be notified.
    function automatic bit fade_step(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] since_frame;
        logic [TIME_W-1:0] elapsed;
        logic [DUTY_W-1:0] span_mag;
        logic [23:0]       prod;
        logic [23:0]       quot;
        if (!fade_run)
            return 1'b0;
        since_frame = now - frame_t;
        if (since_frame < FRAME_MS)
            return 1'b0;
        frame_t = now;
        elapsed = (now >= fade_t0) ? now - fade_t0 : '0;
        if (fade_len == '0 || elapsed >= 32'(fade_len))
        begin
            lamp_duty = fade_to;
            fade_run  = 1'b0;
            return 1'b1;
        end
        // Below the fade length the product fits easily; truncate toward zero.
        span_mag  = (fade_to < fade_from) ? fade_from - fade_to : fade_to - fade_from;
        prod      = 24'(span_mag) * 24'(elapsed[15:0]);
        quot      = prod / 24'(fade_len);
        lamp_duty = (fade_to < fade_from) ? fade_from - quot[7:0] : fade_from + quot[7:0];
        frames    = frames + 1'b1;
        if (frames >= NOTIFY_N)
        begin
            frames = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic lamp_result_t lamp_predict(input lamp_item_t it);
        lamp_result_t      r;
        bit                notify;
        logic [TIME_W-1:0] quiet_ms;
        logic [41:0]       hold_ms;
        notify   = 1'b0;
        quiet_ms = it.now_ms - motion_t;
        hold_ms  = 42'(cfg_hold) * 42'd1000;
        if (it.op == OP_MANUAL)
        begin
            auto_run = 1'b0;
            if (duty_request(it.level, it.now_ms))
                notify = 1'b1;
        end
        else
        begin
            if (cfg_auto_en)
            begin
                if (it.motion)
                begin
                    // Motion only switches a dark light; it renews a held one.
                    if (!auto_run)
                    begin
                        if (lamp_duty == '0)
                        begin
                            void'(duty_request(cfg_auto_lvl, it.now_ms));
                            auto_run = 1'b1;
                            motion_t = it.now_ms;
                            notify   = 1'b1;
                        end
                    end
                    else
                        motion_t = it.now_ms;
                end
                else if (auto_run && 42'(quiet_ms) >= hold_ms)
                begin
                    void'(duty_request('0, it.now_ms));
                    auto_run = 1'b0;
                    notify   = 1'b1;
                end
            end
            if (fade_step(it.now_ms))
                notify = 1'b1;
        end
        r.duty     = lamp_duty;
        r.light_on = (lamp_duty != '0);
        r.auto_on  = auto_run;
        r.fading   = fade_run;
        r.changed  = notify;
        return r;
    endfunction

    function automatic void add_tick(input logic [TIME_W-1:0] at_ms, input logic moving);
        lamp_item_t it;
        it.op     = OP_TICK;
        it.now_ms = at_ms;
        it.motion = moving;
        it.level  = DUTY_W'($urandom);
        lamp_requests.push_back(it);
    endfunction

    function automatic void add_manual(input logic [TIME_W-1:0] at_ms,
                                       input logic [DUTY_W-1:0] lvl);
        lamp_item_t it;
        it.op     = OP_MANUAL;
        it.now_ms = at_ms;
        it.motion = 1'($urandom);
        it.level  = lvl;
        lamp_requests.push_back(it);
    endfunction

    // Mostly steady time with motion bursts and long quiet stretches, plus
    // jumps, steps back in time and manual overrides as noise.
    task automatic queue_random_traffic(input int count);
        int quiet_left;
        int roll;
        quiet_left = 0;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                wall_ms = wall_ms - $urandom_range(1, 100);
            else if (roll < 5)
                wall_ms = $urandom;
            else if (roll < 12)
                wall_ms = wall_ms + $urandom_range(100, 5000);
            else
                wall_ms = wall_ms + $urandom_range(0, 30);

            if ($urandom_range(0, 9) == 0)
            begin
                roll = $urandom_range(0, 3);
                add_manual(wall_ms, (roll == 0) ? 8'd0 :
                                    (roll == 1) ? 8'd255 : DUTY_W'($urandom));
            end
            else if (quiet_left > 0)
            begin
                quiet_left--;
                add_tick(wall_ms, 1'b0);
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    quiet_left = $urandom_range(10, 120);
                add_tick(wall_ms, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Holds valid high across back-to-back writes; the caller lowers it.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_AUTO_ENABLED: cfg_auto_en  = val[0];
            REG_AUTO_LEVEL:   cfg_auto_lvl = val[DUTY_W-1:0];
            REG_AUTO_HOLD:    cfg_hold     = val[HOLD_W-1:0];
            REG_FADE_DUR:     cfg_fade     = val[FADE_W-1:0];
            default:          ;
        endcase
    endtask

    // Unused upper data bits are filled with noise; the block must mask them.
    task automatic apply_settings(input logic en, input logic [DUTY_W-1:0] lvl,
                                  input logic [HOLD_W-1:0] hold,
                                  input logic [FADE_W-1:0] fade,
                                  input bit poke_unmapped);
        @(posedge clk);
        if (poke_unmapped)
            cfg_write(REG_UNMAPPED, 16'hFFFF);
        cfg_write(REG_AUTO_ENABLED, {15'($urandom), en});
        cfg_write(REG_AUTO_LEVEL, {8'($urandom), lvl});
        cfg_write(REG_AUTO_HOLD, hold);
        cfg_write(REG_FADE_DUR, fade);
        cfg_bus.valid <= 1'b0;
    endtask

    // Returns at a falling edge once every request has been answered.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (lamp_requests.size() != 0 || item_bus.valid || predicted_outputs.size() != 0);
    endtask

    task automatic compare_field(input string what, input logic [DUTY_W-1:0] want,
                                 input logic [DUTY_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Request driver: predicts each accepted request, then offers the next.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        lamp_item_t next_item;
        int         send_gap;
        if (!rst_n)
        begin
            item_bus.valid  <= 1'b0;
            item_bus.cmd    <= 1'b0;
            item_bus.now_ms <= '0;
            item_bus.motion <= 1'b0;
            item_bus.level  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
                predicted_outputs.push_back(lamp_predict(offered_item));
            if (!item_bus.valid || item_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_bus.valid <= 1'b0;
                end
                else if (lamp_requests.size() == 0)
                    item_bus.valid <= 1'b0;
                else if (!quiet_run && $urandom_range(0, 7) == 0)
                begin
                    item_bus.valid <= 1'b0;
                    send_gap = $urandom_range(0, 10);
                end
                else
                begin
                    next_item = lamp_requests.pop_front();
                    offered_item    <= next_item;
                    item_bus.valid  <= 1'b1;
                    item_bus.cmd    <= next_item.op;
                    item_bus.now_ms <= next_item.now_ms;
                    item_bus.motion <= next_item.motion;
                    item_bus.level  <= next_item.level;
                end
            end
        end
    end

    // Result monitor: each returned request against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        lamp_result_t want;
        if (!rst_n)
            results_seen <= 0;
        else if (res_bus.valid && res_bus.ready)
        begin
            results_seen <= results_seen + 1;
            if (predicted_outputs.size() == 0)
            begin
                $display("%0t: result with none expected, actual duty %0d", $time,
                         res_bus.duty);
                mismatches++;
            end
            else
            begin
                want = predicted_outputs.pop_front();
                compare_field("duty", want.duty, res_bus.duty);
                compare_field("light_on", want.light_on, res_bus.light_on);
                compare_field("auto_on", want.auto_on, res_bus.auto_on);
                compare_field("fading", want.fading, res_bus.fading);
                compare_field("changed", want.changed, res_bus.changed);
            end
        end
    end

    // Result back-pressure: random bursts and one long hold-off that lets
    // the block fill up and refuse new requests.
    always @(posedge clk or negedge rst_n)
    begin : pace_results
        int take_gap;
        int long_hold;
        bit long_hold_done;
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
            take_gap       = 0;
            long_hold      = 0;
            long_hold_done = 1'b0;
        end
        else if (long_hold > 0)
        begin
            res_bus.ready <= 1'b0;
            long_hold--;
        end
        else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER)
        begin
            res_bus.ready <= 1'b0;
            long_hold      = LONG_HOLD_CYCLES - 1;
            long_hold_done = 1'b1;
        end
        else if (take_gap > 0)
        begin
            res_bus.ready <= 1'b0;
            take_gap--;
        end
        else if (!quiet_run && $urandom_range(0, 7) == 0)
        begin
            res_bus.ready <= 1'b0;
            take_gap = $urandom_range(0, 10);
        end
        else
            res_bus.ready <= 1'b1;
    end

    // Run limit.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        item_bus.valid  = 1'b0;
        item_bus.cmd    = 1'b0;
        item_bus.now_ms = '0;
        item_bus.motion = 1'b0;
        item_bus.level  = '0;
        res_bus.ready   = 1'b0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.index   = '0;
        cfg_bus.data    = '0;
        lamp_reset();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: equal request, fade, throttle, time steps back and
        // a huge elapsed time that ends the fade.
        add_manual(32'd5, 8'd0);
        add_manual(32'd0, 8'd255);
        add_tick(32'd10, 1'b1);
        add_tick(32'd20, 1'b0);
        add_tick(32'd19, 1'b0);
        add_tick(32'hFFFF_FFFF, 1'b0);
        add_tick(32'd0, 1'b0);
        wait_quiet();

        // Instant duty, zero hold, auto level equal to a dark light, and
        // motion ignored while the light is on by hand.
        apply_settings(1'b1, 8'd0, 16'd0, 16'd0, 1'b0);
        @(negedge clk);
        add_tick(32'd100, 1'b1);
        add_manual(32'd100, 8'd0);
        add_tick(32'd110, 1'b1);
        add_tick(32'd120, 1'b1);
        add_tick(32'd130, 1'b0);
        wait_quiet();

        // Motion fade, a tick before the fade start, ten-frame notification,
        // then a manual override that cancels auto mode.
        apply_settings(1'b1, 8'd200, 16'd1, 16'd1000, 1'b1);
        @(negedge clk);
        add_tick(32'd1000, 1'b1);
        add_tick(32'd990, 1'b1);
        for (int k = 0; k < 12; k++)
            add_tick(32'd1010 + 32'(k) * 32'd20, 1'b1);
        add_manual(32'd1250, 8'd128);
        wait_quiet();

        // Random phases across several settings, extremes among them.
        apply_settings(1'b1, 8'd255, 16'd0, 16'd200, 1'b0);
        @(negedge clk);
        wall_ms = 32'hFFFF_F000;
        queue_random_traffic(75);
        wait_quiet();

        apply_settings(1'b1, DUTY_W'($urandom), 16'd1, 16'd100, 1'b0);
        @(negedge clk);
        queue_random_traffic(75);
        wait_quiet();

        apply_settings(1'b0, DUTY_W'($urandom), 16'd60, 16'd500, 1'b0);
        @(negedge clk);
        queue_random_traffic(70);
        wait_quiet();

        apply_settings(1'b1, 8'd0, 16'd2, 16'd0, 1'b0);
        @(negedge clk);
        queue_random_traffic(70);
        wait_quiet();

        apply_settings(1'b1, DUTY_W'($urandom), 16'hFFFF, 16'hFFFF, 1'b0);
        @(negedge clk);
        queue_random_traffic(70);
        wait_quiet();

        // Final stretch runs without idling on either side.
        quiet_run <= 1'b1;
        apply_settings(1'b1, DUTY_W'($urandom), 16'd1,
                       FADE_W'($urandom_range(1, 300)), 1'b0);
        @(negedge clk);
        queue_random_traffic(75);
        wait_quiet();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && predicted_outputs.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
